// File: hdl/frame_pacer_with_vsync_gate_top_macros.svh
// Assertion macros shared by the frame pacer checker.
// Depends on nothing; expects clk and rst_n in the scope of use.
`ifndef FRAME_PACER_WITH_VSYNC_GATE_TOP_MACROS_SVH
`define FRAME_PACER_WITH_VSYNC_GATE_TOP_MACROS_SVH

// Same-cycle implication, ignored while reset is held
`define FPVG_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frame pacer check failed");

// Next-cycle implication, ignored while reset is held
`define FPVG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frame pacer check failed");

`endif

// File: hdl/fpvg_pkg.sv
// Package for the frame pacer: widths, codes, control structs, rate test.
// Depends on nothing; used by every module of the block.
package fpvg_pkg;

  localparam int TIME_W   = 48;
  localparam int RATE_W   = 20;
  localparam int PERIOD_W = 40;
  localparam int MISS_W   = 16;
  localparam int DIV_STEPS = TIME_W;
  localparam int CNT_W    = $clog2(DIV_STEPS);
  localparam logic [TIME_W-1:0] NS_SCALE = 48'd1000000000000;

  // actions
  localparam logic [1:0] ACT_TICK = 2'd0;
  localparam logic [1:0] ACT_CMD  = 2'd1;
  localparam logic [1:0] ACT_HALT = 2'd2;

  // commands
  localparam logic [3:0] CMD_STOP   = 4'd0;
  localparam logic [3:0] CMD_LOAD   = 4'd1;
  localparam logic [3:0] CMD_PAUSE  = 4'd2;
  localparam logic [3:0] CMD_UNLOAD = 4'd3;
  localparam logic [3:0] CMD_GREADY = 4'd4;
  localparam logic [3:0] CMD_DREADY = 4'd5;
  localparam logic [3:0] CMD_PLAY   = 4'd6;
  localparam logic [3:0] CMD_HBEAT  = 4'd7;
  localparam logic [3:0] CMD_HOST   = 4'd8;
  localparam logic [3:0] CMD_CORE   = 4'd9;
  localparam logic [3:0] CMD_VSYNC  = 4'd10;

  // run modes
  localparam logic [2:0] MODE_STOPPED   = 3'd0;
  localparam logic [2:0] MODE_LOADING   = 3'd1;
  localparam logic [2:0] MODE_PAUSED    = 3'd2;
  localparam logic [2:0] MODE_UNLOADING = 3'd3;
  localparam logic [2:0] MODE_PLAYING   = 3'd4;

  // result kinds
  localparam logic [1:0] KIND_FWD    = 2'd0;
  localparam logic [1:0] KIND_MISSED = 2'd1;
  localparam logic [1:0] KIND_HBEAT  = 2'd2;
  localparam logic [1:0] KIND_VOFF   = 2'd3;

  typedef struct packed {
    logic capture;
    logic eval;
    logic finish;
    logic emit;
  } ctl_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_done;
    logic pend_any;
    logic out_free;
  } ctl_sts_t;

  // 2 percent rule: 50*|host-core| <= core
  function automatic logic rates_close(input logic [RATE_W-1:0] host,
                                       input logic [RATE_W-1:0] core);
    logic [RATE_W-1:0] diff;
    logic [RATE_W+5:0] scaled;
    diff   = (host > core) ? host - core : core - host;
    scaled = (RATE_W+6)'(diff) * (RATE_W+6)'(50);
    return scaled <= (RATE_W+6)'(core);
  endfunction

endpackage

// File: hdl/fpvg_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on fpvg_pkg for widths.
module fpvg_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [fpvg_pkg::TIME_W-1:0]     dividend,
  input  logic [fpvg_pkg::PERIOD_W-1:0]   divisor,
  output logic                            done,
  output logic [fpvg_pkg::TIME_W-1:0]     quotient,
  output logic [fpvg_pkg::PERIOD_W-1:0]   remainder
);

  logic                            busy_r;
  logic                            done_r;
  logic [fpvg_pkg::CNT_W-1:0]      cnt_r;
  logic [fpvg_pkg::TIME_W-1:0]     quo_r, quo_nxt;
  logic [fpvg_pkg::PERIOD_W-1:0]   rem_r, rem_nxt;
  logic [fpvg_pkg::PERIOD_W-1:0]   dvs_r;
  logic [fpvg_pkg::PERIOD_W:0]     trial;
  logic                            ge;

  // one shift-subtract step
  always_comb begin
    trial   = {rem_r, quo_r[fpvg_pkg::TIME_W-1]};
    ge      = trial >= {1'b0, dvs_r};
    rem_nxt = ge ? fpvg_pkg::PERIOD_W'(trial - {1'b0, dvs_r})
                 : trial[fpvg_pkg::PERIOD_W-1:0];
    quo_nxt = {quo_r[fpvg_pkg::TIME_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == fpvg_pkg::CNT_W'(fpvg_pkg::DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

// File: hdl/fpvg_dp.sv
// Datapath of the frame pacer: input latch, pacing state, divider, result register.
// Depends on fpvg_pkg and fpvg_div.
module fpvg_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  fpvg_pkg::ctl_cmd_t    cmd,
  output fpvg_pkg::ctl_sts_t    sts,
  input  logic [1:0]            in_action,
  input  logic [47:0]           in_now,
  input  logic [47:0]           in_stamp,
  input  logic [3:0]            in_command,
  input  logic [19:0]           in_payload,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            out_kind,
  output logic [3:0]            out_command,
  output logic [19:0]           out_payload,
  output logic [47:0]           out_stamp,
  output logic [15:0]           out_missed,
  output logic                  out_last
);

  localparam int TW = fpvg_pkg::TIME_W;
  localparam int PW = fpvg_pkg::PERIOD_W;
  localparam int RW = fpvg_pkg::RATE_W;

  // latched item
  logic [1:0]    act_r;
  logic [TW-1:0] now_r, stamp_r;
  logic [3:0]    cmdc_r;
  logic [19:0]   pay_r;

  // pacing state
  logic [2:0]    mode_r;
  logic          vsync_r, gready_r, dready_r, running_r;
  logic [RW-1:0] host_r, core_r;
  logic [PW-1:0] period_r;
  logic [TW-1:0] deadline_r, start_r;

  // pending results: bit0 forward or missed, bit1 heartbeat, bit2 vsync off
  logic [2:0]    pend_r;
  logic          slot_cmd_r;
  logic [15:0]   missed_r;

  // result register
  logic          ov_r;
  logic [1:0]    okind_r;
  logic [3:0]    ocmd_r;
  logic [19:0]   opay_r;
  logic [TW-1:0] ostamp_r;
  logic [15:0]   omiss_r;
  logic          olast_r;

  logic [TW-1:0] elapsed, dividend, base;
  logic [PW-1:0] divisor, new_period;
  logic [TW:0]   dl_sum;
  logic          hit, rate_set, close, pacing, fwd, div_done;
  logic [TW-1:0] quo;
  logic [PW-1:0] rem;
  logic [2:0]    pend_after;

  // decode of the latched item
  always_comb begin
    elapsed  = now_r - start_r;
    hit      = (act_r == fpvg_pkg::ACT_TICK) && running_r && (elapsed >= deadline_r);
    rate_set = (act_r == fpvg_pkg::ACT_CMD) && (cmdc_r == fpvg_pkg::CMD_CORE) &&
               (pay_r[RW-1:0] != '0);
    close    = fpvg_pkg::rates_close(host_r, core_r);
    pacing   = vsync_r && (mode_r == fpvg_pkg::MODE_PLAYING) && close && gready_r;
    fwd      = (cmdc_r != fpvg_pkg::CMD_HBEAT) || pacing;
    dividend = hit ? elapsed - deadline_r : fpvg_pkg::NS_SCALE;
    divisor  = hit ? period_r : PW'(pay_r[RW-1:0]);
    // deadline + q*period equals elapsed - remainder
    base       = elapsed - TW'(rem);
    dl_sum     = {1'b0, base} + (TW+1)'(period_r);
    new_period = (quo[PW-1:0] == '0) ? PW'(1) : quo[PW-1:0];
    pend_after = pend_r & (pend_r - 3'd1);
  end

  fpvg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.eval && (hit || rate_set)),
    .dividend (dividend),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quo),
    .remainder(rem)
  );

  // item latch
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r   <= in_action;
      now_r   <= in_now;
      stamp_r <= in_stamp;
      cmdc_r  <= in_command;
      pay_r   <= in_payload;
    end
  end

  // pacing state and pending results
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= fpvg_pkg::MODE_STOPPED;
      vsync_r    <= 1'b0;
      gready_r   <= 1'b0;
      dready_r   <= 1'b0;
      host_r     <= '0;
      core_r     <= RW'(60000);
      period_r   <= PW'(16666666);
      deadline_r <= TW'(16666666);
      start_r    <= '0;
      running_r  <= 1'b1;
      pend_r     <= '0;
      slot_cmd_r <= 1'b0;
      missed_r   <= '0;
    end else if (cmd.eval) begin
      pend_r     <= '0;
      slot_cmd_r <= 1'b1;
      if (act_r == fpvg_pkg::ACT_HALT) begin
        running_r <= 1'b0;
      end else if (act_r == fpvg_pkg::ACT_CMD) begin
        pend_r <= {2'b00, fwd};
        case (cmdc_r)
          fpvg_pkg::CMD_STOP:   mode_r   <= fpvg_pkg::MODE_STOPPED;
          fpvg_pkg::CMD_LOAD:   mode_r   <= fpvg_pkg::MODE_LOADING;
          fpvg_pkg::CMD_PAUSE:  mode_r   <= fpvg_pkg::MODE_PAUSED;
          fpvg_pkg::CMD_UNLOAD: mode_r   <= fpvg_pkg::MODE_UNLOADING;
          fpvg_pkg::CMD_GREADY: gready_r <= 1'b1;
          fpvg_pkg::CMD_DREADY: dready_r <= 1'b1;
          fpvg_pkg::CMD_PLAY:   mode_r   <= fpvg_pkg::MODE_PLAYING;
          fpvg_pkg::CMD_HOST:   host_r   <= pay_r[RW-1:0];
          fpvg_pkg::CMD_VSYNC:  vsync_r  <= (pay_r != '0);
          default: ;
        endcase
      end
    end else if (cmd.finish) begin
      if (act_r == fpvg_pkg::ACT_TICK) begin
        deadline_r <= dl_sum[TW] ? '1 : dl_sum[TW-1:0];
        missed_r   <= (quo[TW-1:16] != '0) ? 16'hFFFF : quo[15:0];
        slot_cmd_r <= 1'b0;
        pend_r     <= {vsync_r && !close && dready_r, !pacing && gready_r, quo != '0};
        if (vsync_r && !close && dready_r) begin
          vsync_r <= 1'b0;
        end
      end else begin
        core_r     <= pay_r[RW-1:0];
        period_r   <= new_period;
        deadline_r <= TW'(new_period);
        start_r    <= now_r;
        running_r  <= 1'b1;
      end
    end else if (cmd.emit) begin
      pend_r <= pend_after;
    end
  end

  // result register, loaded with the lowest pending result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cmd.emit) begin
      ov_r <= 1'b1;
    end else if (out_ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      ostamp_r <= stamp_r;
      olast_r  <= (pend_after == '0);
      opay_r   <= '0;
      omiss_r  <= '0;
      if (pend_r[0]) begin
        okind_r <= slot_cmd_r ? fpvg_pkg::KIND_FWD : fpvg_pkg::KIND_MISSED;
        ocmd_r  <= slot_cmd_r ? cmdc_r : fpvg_pkg::CMD_STOP;
        opay_r  <= slot_cmd_r ? pay_r : '0;
        omiss_r <= slot_cmd_r ? '0 : missed_r;
      end else if (pend_r[1]) begin
        okind_r <= fpvg_pkg::KIND_HBEAT;
        ocmd_r  <= fpvg_pkg::CMD_HBEAT;
      end else begin
        okind_r <= fpvg_pkg::KIND_VOFF;
        ocmd_r  <= fpvg_pkg::CMD_VSYNC;
      end
    end
  end

  assign sts.need_div = hit || rate_set;
  assign sts.div_done = div_done;
  assign sts.pend_any = (pend_r != '0);
  assign sts.out_free = !ov_r || out_ready;

  assign out_valid   = ov_r;
  assign out_kind    = okind_r;
  assign out_command = ocmd_r;
  assign out_payload = opay_r;
  assign out_stamp   = ostamp_r;
  assign out_missed  = omiss_r;
  assign out_last    = olast_r;

endmodule

// File: hdl/fpvg_ctrl.sv
// Controller of the frame pacer: sequences accept, evaluate, divide and emit.
// Depends on fpvg_pkg.
module fpvg_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  fpvg_pkg::ctl_sts_t  sts,
  output fpvg_pkg::ctl_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EVAL = 4'b0010,
    S_DIV  = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    in_ready    = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) state_nxt = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = sts.need_div ? S_DIV : S_EMIT;
      end
      S_DIV: begin
        cmd.finish = sts.div_done;
        if (sts.div_done) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!sts.pend_any) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.emit = sts.out_free;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: hdl/frame_pacer_with_vsync_gate_top.sv
// Frame pacer with vsync gate, top level.
// Input channel in_*: tuser = action, tdata = now, stamp, command, payload.
// Result channel out_*: tuser = kind, tlast marks the last result of an item.
// One item is handled at a time. A command or halt passes from accept
// through the evaluate state to the emit state, one result at a time; a tick
// that reaches its deadline and a core rate command run the shared divider,
// one quotient bit a cycle, in the divide state before up to three results.
// The first result is registered in the emit state, after any divide state.
// The result register lets the block take its next item while the last
// result still waits; a stalled receiver holds results and so holds the
// block once a further result is due.
// Reset (rst_n low, synchronous) restores the stopped mode, a 60 Hz core
// rate, deadline one period on and the timer running; no clearing pass.
// Depends on fpvg_pkg, fpvg_ctrl, fpvg_dp, fpvg_div.
module frame_pacer_with_vsync_gate_top (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [119:0]  in_tdata,   // now_ns[47:0], stamp[95:48], command[99:96],
                                    // payload[119:100]
  input  logic [1:0]    in_tuser,   // action
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [87:0]   out_tdata,  // out_command[3:0], out_payload[23:4],
                                    // out_stamp[71:24], missed_frames[87:72]
  output logic [1:0]    out_tuser,  // kind
  output logic          out_tlast   // last
);

  fpvg_pkg::ctl_cmd_t cmd;
  fpvg_pkg::ctl_sts_t sts;
  logic [3:0]  o_cmd;
  logic [19:0] o_pay;
  logic [47:0] o_stamp;
  logic [15:0] o_miss;

  fpvg_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_tvalid),
    .in_ready(in_tready),
    .sts     (sts),
    .cmd     (cmd)
  );

  fpvg_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_action  (in_tuser),
    .in_now     (in_tdata[47:0]),
    .in_stamp   (in_tdata[95:48]),
    .in_command (in_tdata[99:96]),
    .in_payload (in_tdata[119:100]),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_kind   (out_tuser),
    .out_command(o_cmd),
    .out_payload(o_pay),
    .out_stamp  (o_stamp),
    .out_missed (o_miss),
    .out_last   (out_tlast)
  );

  assign out_tdata = {o_miss, o_stamp, o_pay, o_cmd};

endmodule

// File: hdl/fpvg_checker.sv
// Port-level checker for the frame pacer, bound to the top level.
// Depends on frame_pacer_with_vsync_gate_top_macros.svh and fpvg_pkg.
`include "frame_pacer_with_vsync_gate_top_macros.svh"

module fpvg_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          out_tvalid,
  input logic          out_tready,
  input logic [87:0]   out_tdata,
  input logic [1:0]    out_tuser,
  input logic          out_tlast
);

  // a stalled result holds its content
  `FPVG_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))

  // vsync-off is always the final result of a tick
  `FPVG_ASSERT_NOW(a_voff_last, out_tvalid && out_tuser == fpvg_pkg::KIND_VOFF, out_tlast)

  // heartbeat carries its code and an empty payload
  `FPVG_ASSERT_NOW(a_hbeat_form, out_tvalid && out_tuser == fpvg_pkg::KIND_HBEAT, out_tdata[3:0] == fpvg_pkg::CMD_HBEAT && out_tdata[23:4] == '0)

  // missed count shows only on a missed frames report
  `FPVG_ASSERT_NOW(a_missed_only, out_tvalid && out_tuser != fpvg_pkg::KIND_MISSED, out_tdata[87:72] == '0)

endmodule

bind frame_pacer_with_vsync_gate_top fpvg_checker u_fpvg_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser),
  .out_tlast (out_tlast)
);

// File: test/testbench.sv
// Self-checking testbench for frame_pacer_with_vsync_gate_top.
// Predicts results from its own pacer model, drives ticks and commands with random gaps.
// Depends on fpvg_pkg and the frame_pacer_with_vsync_gate_top RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [1:0]  action;
    logic [47:0] now_ns;
    logic [47:0] stamp;
    logic [3:0]  command;
    logic [19:0] payload;
  } pacer_item_t;

  typedef struct {
    logic [1:0]  kind;
    logic [3:0]  command;
    logic [19:0] payload;
    logic [47:0] stamp;
    logic [15:0] missed;
    logic        last;
  } pacer_result_t;

  localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;
  localparam int          CYCLE_LIMIT = 400000;
  // action code with no meaning, and command codes outside the known set
  localparam logic [1:0]  ACT_UNUSED = 2'd3;
  localparam logic [3:0]  CMD_OTHER_LO = 4'd11;
  localparam logic [3:0]  CMD_OTHER_HI = 4'd15;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [119:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [87:0] out_tdata;
  logic [1:0] out_tuser;
  logic out_tlast;

  frame_pacer_with_vsync_gate_top DUT (.*);

  always #4 clk = ~clk;

  // predictor state
  logic [2:0]  p_mode;
  logic        p_vsync, p_gready, p_dready, p_running;
  logic [19:0] p_host, p_core;
  logic [39:0] p_period;
  logic [47:0] p_deadline, p_start;

  pacer_item_t   pending_items[$];
  pacer_result_t expected_results[$];
  int errors = 0;
  int results_seen = 0;
  int ticks_sent = 0;
  int cmds_sent = 0;
  bit stimulus_done = 0;
  bit hold_sender = 0;
  longint cycles = 0;

  function automatic bit rates_near();
    logic [19:0] d;
    d = (p_host > p_core) ? p_host - p_core : p_core - p_host;
    return 64'(d) * 50 <= 64'(p_core);
  endfunction

  function automatic bit pacing_ok();
    return p_vsync && p_mode == fpvg_pkg::MODE_PLAYING && rates_near() && p_gready;
  endfunction

  task automatic push_result(input logic [1:0] k, input logic [3:0] c,
                             input logic [19:0] pl, input logic [47:0] st,
                             input logic [15:0] m);
    pacer_result_t r;
    r.kind = k; r.command = c; r.payload = pl; r.stamp = st; r.missed = m; r.last = 1'b0;
    expected_results.push_back(r);
  endtask

  // Work out the results of one accepted item and update the predicted state
  task automatic predict_pacer(input pacer_item_t it);
    int n0;
    logic [47:0] elapsed, headroom;
    logic [63:0] q, add;
    logic [63:0] per;
    bit fwd;
    n0 = expected_results.size();
    if (it.action == fpvg_pkg::ACT_TICK) begin
      per = 64'(p_period);
      if (p_running && p_core != 0 && per != 0) begin
        elapsed = it.now_ns - p_start;
        if (elapsed >= p_deadline) begin
          q = 64'(elapsed - p_deadline) / per;
          headroom = TIME_MAX - p_deadline;
          add = q * per;
          if (per > 64'(headroom) - add) p_deadline = TIME_MAX;
          else p_deadline = p_deadline + 48'(add) + 48'(per);
          if (q >= 1)
            push_result(fpvg_pkg::KIND_MISSED, fpvg_pkg::CMD_STOP, '0, it.stamp,
                        (q > 65535) ? 16'hFFFF : 16'(q));
          if (!pacing_ok() && p_gready)
            push_result(fpvg_pkg::KIND_HBEAT, fpvg_pkg::CMD_HBEAT, '0, it.stamp, '0);
          if (p_vsync && !rates_near() && p_dready) begin
            p_vsync = 1'b0;
            push_result(fpvg_pkg::KIND_VOFF, fpvg_pkg::CMD_VSYNC, '0, it.stamp, '0);
          end
        end
      end
    end else if (it.action == fpvg_pkg::ACT_CMD) begin
      fwd = 1;
      case (it.command)
        fpvg_pkg::CMD_STOP:   p_mode = fpvg_pkg::MODE_STOPPED;
        fpvg_pkg::CMD_LOAD:   p_mode = fpvg_pkg::MODE_LOADING;
        fpvg_pkg::CMD_PAUSE:  p_mode = fpvg_pkg::MODE_PAUSED;
        fpvg_pkg::CMD_UNLOAD: p_mode = fpvg_pkg::MODE_UNLOADING;
        fpvg_pkg::CMD_GREADY: p_gready = 1'b1;
        fpvg_pkg::CMD_DREADY: p_dready = 1'b1;
        fpvg_pkg::CMD_PLAY:   p_mode = fpvg_pkg::MODE_PLAYING;
        fpvg_pkg::CMD_HBEAT:  fwd = pacing_ok();
        fpvg_pkg::CMD_HOST:   p_host = it.payload;
        fpvg_pkg::CMD_CORE: begin
          if (it.payload != 0) begin
            p_core = it.payload;
            p_period = 40'(64'd1000000000000 / 64'(it.payload));
            if (p_period == 0) p_period = 40'd1;
            p_deadline = 48'(p_period);
            p_start = it.now_ns;
            p_running = 1'b1;
          end
        end
        fpvg_pkg::CMD_VSYNC:  p_vsync = (it.payload != 0);
        default: ;
      endcase
      if (fwd) push_result(fpvg_pkg::KIND_FWD, it.command, it.payload, it.stamp, '0);
    end else if (it.action == fpvg_pkg::ACT_HALT) begin
      p_running = 1'b0;
    end
    if (expected_results.size() > n0)
      expected_results[expected_results.size()-1].last = 1'b1;
  endtask

  // Driver: presents queued items with random gaps
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        predict_pacer(pending_items.pop_front());
        send_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      end
      if ((!in_tvalid || in_tready) ) begin
        if (send_gap > 0 || hold_sender || pending_items.size() == 0 ||
            (in_tvalid && in_tready && send_gap > 0)) begin
          in_tvalid <= 1'b0;
          if (send_gap > 0) send_gap--;
        end else begin
          in_tvalid <= 1'b1;
          in_tuser  <= pending_items[0].action;
          in_tdata  <= {pending_items[0].payload, pending_items[0].command,
                        pending_items[0].stamp, pending_items[0].now_ns};
        end
      end
    end
  end

  // Monitor: checks each result transfer against the oldest expectation
  int stall = 0;
  always @(posedge clk) begin
    pacer_result_t e;
    cycles++;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("unexpected result kind=%0d cmd=%0d", out_tuser, out_tdata[3:0]);
          errors++;
        end else begin
          e = expected_results.pop_front();
          if (out_tuser !== e.kind) begin
            $error("kind: expected %0d, got %0d", e.kind, out_tuser); errors++;
          end
          if (out_tdata[3:0] !== e.command) begin
            $error("out_command: expected %0d, got %0d", e.command, out_tdata[3:0]); errors++;
          end
          if (out_tdata[23:4] !== e.payload) begin
            $error("out_payload: expected %0h, got %0h", e.payload, out_tdata[23:4]); errors++;
          end
          if (out_tdata[71:24] !== e.stamp) begin
            $error("out_stamp: expected %0h, got %0h", e.stamp, out_tdata[71:24]); errors++;
          end
          if (out_tdata[87:72] !== e.missed) begin
            $error("missed_frames: expected %0d, got %0d", e.missed, out_tdata[87:72]);
            errors++;
          end
          if (out_tlast !== e.last) begin
            $error("last: expected %0b, got %0b", e.last, out_tlast); errors++;
          end
        end
        stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        stall--;
      end else begin
        out_tready <= 1'b1;
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("frame_pacer_with_vsync_gate_top test failed");
      $finish;
    end
  end

  // Stimulus helpers
  logic [47:0] clock_ns = 48'd0;

  task automatic add_item(input logic [1:0] a, input logic [47:0] now,
                          input logic [47:0] st, input logic [3:0] c, input logic [19:0] pl);
    pacer_item_t it;
    it.action = a; it.now_ns = now; it.stamp = st; it.command = c; it.payload = pl;
    pending_items.push_back(it);
    if (a == fpvg_pkg::ACT_TICK) ticks_sent++; else cmds_sent++;
  endtask

  function automatic logic [47:0] rand48();
    return {16'($urandom), $urandom};
  endfunction

  task automatic add_cmd(input logic [3:0] c, input logic [19:0] pl);
    add_item(fpvg_pkg::ACT_CMD, clock_ns, rand48(), c, pl);
  endtask

  task automatic add_tick();
    int r;
    r = $urandom_range(0, 9);
    // mostly on time, sometimes late by many periods, rarely anywhere
    if (r < 6) clock_ns = clock_ns + 48'($urandom_range(8000000, 20000000));
    else if (r < 9) clock_ns = clock_ns + 48'($urandom_range(0, 2000000000));
    else clock_ns = rand48();
    add_item(fpvg_pkg::ACT_TICK, clock_ns, rand48(), 4'($urandom), 20'($urandom));
  endtask

  initial begin
    int kind_pick;
    p_mode = fpvg_pkg::MODE_STOPPED; p_vsync = 0; p_gready = 0; p_dready = 0;
    p_host = '0; p_core = 20'd60000; p_period = 40'd16666666;
    p_deadline = 48'd16666666; p_start = '0; p_running = 1'b1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset deadline, every command, extremes, late ticks, saturation
    add_item(fpvg_pkg::ACT_TICK, 48'd16666665, 48'd0, 4'd0, 20'd0);
    add_item(fpvg_pkg::ACT_TICK, 48'd16666666, TIME_MAX, 4'hF, 20'hFFFFF);
    add_cmd(fpvg_pkg::CMD_GREADY, 20'd0);
    add_item(fpvg_pkg::ACT_TICK, 48'd100000000, 48'd1, 4'd0, 20'd0);
    add_cmd(fpvg_pkg::CMD_DREADY, 20'hFFFFF);
    add_cmd(fpvg_pkg::CMD_VSYNC, 20'd1);
    add_cmd(fpvg_pkg::CMD_HBEAT, 20'd5);
    add_item(fpvg_pkg::ACT_TICK, 48'd400000000, 48'd2, 4'd0, 20'd0);
    add_cmd(fpvg_pkg::CMD_HOST, 20'd60000);
    add_cmd(fpvg_pkg::CMD_PLAY, 20'd0);
    add_cmd(fpvg_pkg::CMD_VSYNC, 20'h80000);
    add_cmd(fpvg_pkg::CMD_HBEAT, 20'd3);
    add_item(fpvg_pkg::ACT_TICK, 48'd500000000, 48'd3, 4'd0, 20'd0);
    add_cmd(fpvg_pkg::CMD_CORE, 20'd0);
    add_cmd(fpvg_pkg::CMD_CORE, 20'd1);
    add_item(fpvg_pkg::ACT_TICK, TIME_MAX, 48'd4, 4'd0, 20'd0);
    add_cmd(fpvg_pkg::CMD_CORE, 20'hFFFFF);
    add_item(fpvg_pkg::ACT_TICK, TIME_MAX, 48'd5, 4'd0, 20'd0);
    add_cmd(fpvg_pkg::CMD_CORE, 20'd60000);
    add_cmd(fpvg_pkg::CMD_LOAD, 20'd0); add_cmd(fpvg_pkg::CMD_PAUSE, 20'd0);
    add_cmd(fpvg_pkg::CMD_UNLOAD, 20'd0);
    add_cmd(fpvg_pkg::CMD_STOP, 20'd0); add_cmd(CMD_OTHER_LO, 20'd7);
    add_cmd(CMD_OTHER_HI, 20'd9);
    add_item(fpvg_pkg::ACT_HALT, TIME_MAX, TIME_MAX, 4'hF, 20'hFFFFF);
    add_item(fpvg_pkg::ACT_TICK, TIME_MAX, 48'd6, 4'd0, 20'd0);
    add_item(ACT_UNUSED, TIME_MAX, TIME_MAX, 4'hF, 20'hFFFFF);
    clock_ns = 48'd0;
    add_cmd(fpvg_pkg::CMD_CORE, 20'd60000);

    // Random: pacing sessions of ticks mixed with commands and a little noise
    for (int i = 0; i < 430; i++) begin
      kind_pick = $urandom_range(0, 99);
      if (i == 200) begin
        wait (pending_items.size() == 0 && expected_results.size() == 0);
        hold_sender = 1;
        repeat (80) @(posedge clk);
        hold_sender = 0;
      end
      if (kind_pick < 55) add_tick();
      else if (kind_pick < 62) add_cmd(fpvg_pkg::CMD_HOST, ($urandom_range(0, 1) != 0) ?
                                        20'(p_core + $urandom_range(0, 2000) - 1000) :
                                        20'($urandom));
      else if (kind_pick < 66) begin
        clock_ns = rand48() & 48'h0000_FFFF_FFFF;
        add_cmd(fpvg_pkg::CMD_CORE, ($urandom_range(0, 9) == 0) ? 20'($urandom) :
                          20'($urandom_range(50000, 62000)));
      end
      else if (kind_pick < 72) add_cmd(fpvg_pkg::CMD_VSYNC, 20'($urandom_range(0, 3)));
      else if (kind_pick < 80) add_cmd(fpvg_pkg::CMD_HBEAT, 20'($urandom));
      else if (kind_pick < 95) add_cmd(4'($urandom_range(0, 6)), 20'($urandom));
      else if (kind_pick < 97) add_cmd(4'($urandom_range(11, 15)), 20'($urandom));
      else if (kind_pick < 98)
        add_item(fpvg_pkg::ACT_HALT, rand48(), rand48(), 4'($urandom), 20'($urandom));
      else add_item(ACT_UNUSED, rand48(), rand48(), 4'($urandom), 20'($urandom));
      // keep the queue short so the predictor state used for steering stays current
      wait (pending_items.size() < 4);
    end
    stimulus_done = 1;
  end

  // End of run
  initial begin
    wait (stimulus_done);
    wait (pending_items.size() == 0 && !in_tvalid && expected_results.size() == 0);
    repeat (200) @(posedge clk);
    $display("Covered %0d ticks and %0d commands/halts, %0d results checked.",
             ticks_sent, cmds_sent, results_seen);
    if (errors == 0 && expected_results.size() == 0)
      $display("frame_pacer_with_vsync_gate_top test passed");
    else
      $display("frame_pacer_with_vsync_gate_top test failed");
    $finish;
  end
endmodule
